// ===== rtl/gto_pkg.sv =====
// shared types and constants for the graph traversal order block
package gto_pkg;

  localparam int unsigned MaxNodesDef  = 64;
  localparam int unsigned NodeW        = 7;
  localparam int unsigned NodeCountRst = 64;

  typedef enum logic [1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_TRAVERSE = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    CFG_NODE_COUNT = 1'd0,
    CFG_ORDER      = 1'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_EDGE_CHK,
    ST_EDGE_WA,
    ST_EDGE_WB,
    ST_ROW,
    ST_DFS_SCAN,
    ST_DFS_POP,
    ST_BFS_POP,
    ST_BFS_DEQ,
    ST_BFS_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
  } in_word_t;

  typedef struct packed {
    logic [NodeW-1:0] visit_node;
    logic             last_visit;
  } out_word_t;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [NodeW-1:0] next;
  } stk_word_t;

endpackage

// ===== rtl/graph_traversal_order_top.sv =====
// graph traversal order block: adjacency matrix with depth- and breadth-first walks
//
// The adjacency matrix lives in one synchronous memory of MAX_NODES rows, one row
// per node. After reset a clearing pass writes one zero row per cycle until all
// MAX_NODES rows are clear, before the first word is taken; a clear-graph word
// repeats that pass (input stalled until the pass ends). An add-edge word keeps
// the input stalled after it is taken through a range check and read of the
// first row, a write of the first row while the second is read, and a write of
// the second row (only the check when an endpoint is out of range). A traversal
// whose start is out of range leaves the block idle and emits nothing. A walk
// reads one adjacency row per visited node and then scans that row one candidate
// index per cycle, except while a node found by the depth-first walk waits for
// the output register. The sequencer handles one input word at a time. The most
// recently visited node waits in a pending register until the walk knows
// whether another node follows, so the last flag is exact; results leave
// through an output register that holds a word until the receiver takes it.
// The depth-first stack (node, next neighbour index per level) and the
// breadth-first queue (node numbers) sit in two more small memories.
module graph_traversal_order_top
  import gto_pkg::*;
#(
  parameter int unsigned MAX_NODES = MaxNodesDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [NodeW-1:0]     cfg_wdata
);

  localparam int unsigned AW = $clog2(MAX_NODES);

  // configuration
  logic [NodeW-1:0] node_count_r;
  logic             order_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NodeW'(NodeCountRst);
      order_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_COUNT: node_count_r <= cfg_wdata;
        CFG_ORDER:      order_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective node count, min(node_count, MAX_NODES)
  logic [NodeW-1:0] n_eff;
  assign n_eff = (node_count_r > NodeW'(MAX_NODES)) ? NodeW'(MAX_NODES) : node_count_r;

  // adjacency memory
  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic                 adj_we;
  logic [AW-1:0]        adj_waddr;
  logic [MAX_NODES-1:0] adj_wdata;
  logic [AW-1:0]        adj_raddr;
  logic [MAX_NODES-1:0] adj_rdata_r;
  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    adj_rdata_r <= adj_mem[adj_raddr];
  end

  // walk stack (node, next index) and queue
  stk_word_t        stk_mem [MAX_NODES];
  logic [NodeW-1:0] que_mem [MAX_NODES];
  logic             stk_we, que_we;
  logic [AW-1:0]    stk_waddr, que_waddr;
  stk_word_t        stk_wdata;
  logic [NodeW-1:0] que_wdata;
  logic [AW-1:0]    stk_raddr, que_raddr;
  stk_word_t        stk_rdata_r;
  logic [NodeW-1:0] que_rdata_r;
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (que_we) que_mem[que_waddr] <= que_wdata;
    stk_rdata_r <= stk_mem[stk_raddr];
    que_rdata_r <= que_mem[que_raddr];
  end

  // control registers
  state_t               st_r, st_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;      // clearing pass row
  logic [MAX_NODES-1:0] vis_r, vis_nxt;
  logic [NodeW-1:0]     a_r, a_nxt, b_r, b_nxt;
  logic [AW:0]          sp_r, sp_nxt;        // stack depth
  logic [AW:0]          qh_r, qh_nxt, qt_r, qt_nxt;
  logic [NodeW-1:0]     cur_r, cur_nxt;      // node whose row is scanned
  logic [NodeW-1:0]     idx_r, idx_nxt;      // candidate neighbour
  logic [MAX_NODES-1:0] row_r, row_nxt;
  logic                 ov_r, ov_nxt;
  out_word_t            od_r, od_nxt;
  logic [NodeW-1:0]     pend_r, pend_nxt;    // node waiting to be emitted
  logic                 pend_v_r, pend_v_nxt;

  logic in_acc, out_acc;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_CLEAR;
      clr_r    <= '0;
      vis_r    <= '0;
      sp_r     <= '0;
      qh_r     <= '0;
      qt_r     <= '0;
      ov_r     <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      clr_r    <= clr_nxt;
      vis_r    <= vis_nxt;
      sp_r     <= sp_nxt;
      qh_r     <= qh_nxt;
      qt_r     <= qt_nxt;
      ov_r     <= ov_nxt;
      pend_v_r <= pend_v_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    cur_r  <= cur_nxt;
    idx_r  <= idx_nxt;
    row_r  <= row_nxt;
    od_r   <= od_nxt;
    pend_r <= pend_nxt;
  end

  // helpers
  op_t           in_op;
  logic [AW-1:0] start_bit, a_bit, b_bit, idx_bit;
  logic          start_ok, a_ok, b_ok;
  logic          idx_end, idx_hit, out_free, push_ok, sp_last, q_empty;
  assign in_op     = op_t'(in_data.op);
  assign start_bit = AW'(in_data.node_a - NodeW'(1));
  assign a_bit     = AW'(a_r - NodeW'(1));
  assign b_bit     = AW'(b_r - NodeW'(1));
  assign idx_bit   = AW'(idx_r - NodeW'(1));
  assign start_ok  = (in_data.node_a >= NodeW'(1)) && (in_data.node_a <= n_eff);
  assign a_ok      = (a_r >= NodeW'(1)) && (a_r <= n_eff);
  assign b_ok      = (b_r >= NodeW'(1)) && (b_r <= n_eff);
  assign idx_end   = idx_r > n_eff;
  assign idx_hit   = row_r[idx_bit] && !vis_r[idx_bit];
  assign out_free  = !ov_r || out_acc;
  assign push_ok   = sp_r < (AW+1)'(MAX_NODES);
  assign sp_last   = sp_r == (AW+1)'(1);
  assign q_empty   = qh_r == qt_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_ADD_EDGE: st_nxt = ST_EDGE_CHK;
            OP_TRAVERSE: begin
              if (start_ok) st_nxt = order_r ? ST_BFS_POP : ST_ROW;
            end
            OP_CLEAR:    st_nxt = ST_CLEAR;
            OP_NONE:     st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_r == AW'(MAX_NODES - 1)) st_nxt = ST_IDLE;
      end
      ST_EDGE_CHK: st_nxt = (a_ok && b_ok) ? ST_EDGE_WA : ST_IDLE;
      ST_EDGE_WA:  st_nxt = ST_EDGE_WB;
      ST_EDGE_WB:  st_nxt = ST_IDLE;
      ST_ROW:      st_nxt = order_r ? ST_BFS_SCAN : ST_DFS_SCAN;
      ST_DFS_SCAN: begin
        if (idx_end) st_nxt = sp_last ? ST_FLUSH : ST_DFS_POP;
        else if (idx_hit && out_free && push_ok) st_nxt = ST_ROW;
      end
      ST_DFS_POP:  st_nxt = ST_ROW;
      ST_BFS_POP:  st_nxt = q_empty ? ST_FLUSH : ST_BFS_DEQ;
      ST_BFS_DEQ: begin
        if (!pend_v_r || out_free) st_nxt = ST_ROW;
      end
      ST_BFS_SCAN: begin
        if (idx_end) st_nxt = ST_BFS_POP;
      end
      ST_FLUSH: begin
        if (out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    clr_nxt    = clr_r;
    vis_nxt    = vis_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    sp_nxt     = sp_r;
    qh_nxt     = qh_r;
    qt_nxt     = qt_r;
    cur_nxt    = cur_r;
    idx_nxt    = idx_r;
    row_nxt    = row_r;
    ov_nxt     = ov_r && !out_acc;
    od_nxt     = od_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    adj_we     = 1'b0;
    adj_waddr  = '0;
    adj_wdata  = '0;
    adj_raddr  = a_bit;
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    stk_raddr  = AW'(sp_r - (AW+1)'(2));   // parent of the top level
    que_we     = 1'b0;
    que_waddr  = '0;
    que_wdata  = '0;
    que_raddr  = AW'(qh_r);

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          a_nxt = in_data.node_a;
          b_nxt = in_data.node_b;
          unique case (in_op)
            OP_ADD_EDGE: ;
            OP_TRAVERSE: begin
              vis_nxt = '0;
              if (start_ok) begin
                vis_nxt[start_bit] = 1'b1;
                cur_nxt = in_data.node_a;
                idx_nxt = NodeW'(1);
                if (order_r) begin
                  // start node goes through the queue like every other node
                  que_we    = 1'b1;
                  que_waddr = '0;
                  que_wdata = in_data.node_a;
                  qh_nxt    = '0;
                  qt_nxt    = (AW+1)'(1);
                end else begin
                  pend_nxt   = in_data.node_a;
                  pend_v_nxt = 1'b1;
                  sp_nxt     = (AW+1)'(1);
                  adj_raddr  = start_bit;
                end
              end
            end
            OP_CLEAR: begin
              vis_nxt = '0;
              clr_nxt = '0;
            end
            OP_NONE: ;
          endcase
        end
      end
      ST_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
      end
      ST_EDGE_CHK: adj_raddr = a_bit;
      ST_EDGE_WA: begin
        // a self loop reads the old row here and writes the same value next
        adj_we           = 1'b1;
        adj_waddr        = a_bit;
        adj_wdata        = adj_rdata_r;
        adj_wdata[b_bit] = 1'b1;
        adj_raddr        = b_bit;
      end
      ST_EDGE_WB: begin
        adj_we           = 1'b1;
        adj_waddr        = b_bit;
        adj_wdata        = adj_rdata_r;
        adj_wdata[a_bit] = 1'b1;
      end
      ST_ROW: row_nxt = adj_rdata_r;
      ST_DFS_SCAN: begin
        if (idx_end) begin
          sp_nxt = sp_r - (AW+1)'(1);
        end else if (idx_hit) begin
          if (out_free) begin
            ov_nxt           = 1'b1;
            od_nxt           = '{visit_node: pend_r, last_visit: 1'b0};
            pend_nxt         = idx_r;
            vis_nxt[idx_bit] = 1'b1;
            if (push_ok) begin
              // save where the parent resumes, then descend
              stk_we    = 1'b1;
              stk_waddr = AW'(sp_r - (AW+1)'(1));
              stk_wdata = '{node: cur_r, next: idx_r + NodeW'(1)};
              sp_nxt    = sp_r + (AW+1)'(1);
              cur_nxt   = idx_r;
              idx_nxt   = NodeW'(1);
              adj_raddr = idx_bit;
            end else begin
              // stack full: stay on this level
              idx_nxt = idx_r + NodeW'(1);
            end
          end
        end else begin
          idx_nxt = idx_r + NodeW'(1);
        end
      end
      ST_DFS_POP: begin
        cur_nxt   = stk_rdata_r.node;
        idx_nxt   = stk_rdata_r.next;
        adj_raddr = AW'(stk_rdata_r.node - NodeW'(1));
      end
      ST_BFS_POP: ;
      ST_BFS_DEQ: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            ov_nxt = 1'b1;
            od_nxt = '{visit_node: pend_r, last_visit: 1'b0};
          end
          pend_nxt   = que_rdata_r;
          pend_v_nxt = 1'b1;
          cur_nxt    = que_rdata_r;
          idx_nxt    = NodeW'(1);
          qh_nxt     = qh_r + (AW+1)'(1);
          adj_raddr  = AW'(que_rdata_r - NodeW'(1));
        end
      end
      ST_BFS_SCAN: begin
        if (!idx_end) begin
          if (idx_hit && qt_r < (AW+1)'(MAX_NODES)) begin
            que_we           = 1'b1;
            que_waddr        = AW'(qt_r);
            que_wdata        = idx_r;
            qt_nxt           = qt_r + (AW+1)'(1);
            vis_nxt[idx_bit] = 1'b1;
          end
          idx_nxt = idx_r + NodeW'(1);
        end
      end
      ST_FLUSH: begin
        // walk done: the pending node is the last one
        if (out_free) begin
          ov_nxt     = 1'b1;
          od_nxt     = '{visit_node: pend_r, last_visit: 1'b1};
          pend_v_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/gto_checker.sv =====
// port-level checks for the graph traversal order block
module gto_checker
  import gto_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // visited node numbers are never zero
  a_node_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.visit_node != '0)
    else $error("zero node number emitted");

  // no word taken while a walk is still producing
  a_busy_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_visit |-> in_stall)
    else $error("input accepted during a walk");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind graph_traversal_order_top gto_checker u_gto_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
